>>> rtl/mrf_pkg.sv
package mrf_pkg;

    // Input command codes.
    typedef enum logic [1:0] {
        CMD_START   = 2'd0,
        CMD_PAYLOAD = 2'd1,
        CMD_RX_BYTE = 2'd2,
        CMD_RX_END  = 2'd3
    } t_cmd;

    // Result kinds.
    typedef enum logic [1:0] {
        KIND_TX      = 2'd0,
        KIND_VERDICT = 2'd1,
        KIND_REJECT  = 2'd2
    } t_out_kind;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        BK_BYTES,
        BK_CRC_LO,
        BK_CRC_HI
    } t_back_state;

    // Function selector codes.
    localparam logic [2:0] FSEL_READ_INPUTS = 3'd0;
    localparam logic [2:0] FSEL_WRITE_COILS = 3'd1;
    localparam logic [2:0] FSEL_WRITE_REGS  = 3'd2;
    localparam logic [2:0] FSEL_WRITE_SINGLE = 3'd3;
    localparam logic [2:0] FSEL_READ_REGS   = 3'd4;

    // Modbus function codes on the wire.
    localparam logic [7:0] FC_READ_INPUTS  = 8'h02;
    localparam logic [7:0] FC_WRITE_COILS  = 8'h0F;
    localparam logic [7:0] FC_WRITE_REGS   = 8'h10;
    localparam logic [7:0] FC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FC_READ_REGS    = 8'h04;

    // Count limits.
    localparam int          COUNT_W          = 11;
    localparam int          MAX_COILS_INT    = 2000;
    localparam int          COIL_WRITE_INT   = (MAX_COILS_INT < 1968) ? MAX_COILS_INT : 1968;
    localparam logic [10:0] MAX_COILS        = 11'(MAX_COILS_INT);
    localparam logic [10:0] COIL_WRITE_LIMIT = 11'(COIL_WRITE_INT);
    localparam logic [10:0] REG_WRITE_LIMIT  = 11'd123;
    localparam logic [10:0] REG_READ_LIMIT   = 11'd125;

    localparam logic [7:0]  SLAVE_ADDR_RESET = 8'h36;
    localparam logic [15:0] CRC_INIT         = 16'hFFFF;
    localparam logic [15:0] CRC_POLY         = 16'hA001;
    localparam logic [8:0]  RX_LEN_MAX       = 9'h1FF;
    localparam logic [8:0]  RX_LEN_MIN_OK    = 9'd3;

    // Queue between front and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Header bytes a single job can carry.
    localparam int JOB_BYTES = 7;
    localparam int JIDX_W    = $clog2(JOB_BYTES);

    typedef struct packed {
        logic [1:0]  command;
        logic [2:0]  function_sel;
        logic [15:0] reg_address;
        logic [10:0] item_count;
        logic [15:0] data_word;
        logic [7:0]  rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [1:0] out_kind;
        logic [7:0] tx_byte;
        logic       frame_last;
        logic       response_ok;
    } t_out_item;

    // One unit of work for the back end.
    typedef struct packed {
        t_out_kind                      kind;
        logic [JIDX_W-1:0]              nbytes;
        logic [JOB_BYTES-1:0][7:0]      bytes;
        logic                           clr_crc;
        logic                           add_crc;
        logic                           ok;
    } t_job;

    // CRC-16/MODBUS update by one byte, reflected polynomial.
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // Function code for a selector.
    function automatic logic [7:0] fn_code(input logic [2:0] fsel);
        logic [7:0] code;
        case (fsel)
            FSEL_READ_INPUTS:  code = FC_READ_INPUTS;
            FSEL_WRITE_COILS:  code = FC_WRITE_COILS;
            FSEL_WRITE_REGS:   code = FC_WRITE_REGS;
            FSEL_WRITE_SINGLE: code = FC_WRITE_SINGLE;
            FSEL_READ_REGS:    code = FC_READ_REGS;
            default:           code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

>>> rtl/mrf_front.sv
module mrf_front
    import mrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_accept,
    input  t_in_item   i_item,
    output logic       o_push,
    output t_job       o_job
);

    logic [7:0]         r_slave_addr;
    logic [2:0]         r_active_fn, n_active_fn;
    logic [COUNT_W-1:0] r_items_left, n_items_left;
    logic [7:0]         r_coil_acc, n_coil_acc;
    logic [2:0]         r_coil_pos, n_coil_pos;
    logic [15:0]        r_rx_crc, n_rx_crc;
    logic [8:0]         r_rx_len, n_rx_len;

    logic               job_valid;
    t_job               job;
    logic [COUNT_W-1:0] limit;
    logic [COUNT_W-1:0] left_dec;
    logic [7:0]         coil_next;
    logic [2:0]         pos_inc;
    logic [11:0]        byte_cnt_sum;

    // Count limit per function.
    always_comb begin
        case (i_item.function_sel)
            FSEL_READ_INPUTS: limit = MAX_COILS;
            FSEL_WRITE_COILS: limit = COIL_WRITE_LIMIT;
            FSEL_WRITE_REGS:  limit = REG_WRITE_LIMIT;
            FSEL_READ_REGS:   limit = REG_READ_LIMIT;
            default:          limit = '0;
        endcase
    end

    assign left_dec     = r_items_left - 11'd1;
    assign coil_next    = r_coil_acc | (8'(i_item.data_word[0]) << r_coil_pos);
    assign pos_inc      = r_coil_pos + 3'd1;
    assign byte_cnt_sum = {1'b0, i_item.item_count} + 12'd7;

    // Classify the item, update framing state and build the job.
    always_comb begin
        n_active_fn  = r_active_fn;
        n_items_left = r_items_left;
        n_coil_acc   = r_coil_acc;
        n_coil_pos   = r_coil_pos;
        n_rx_crc     = r_rx_crc;
        n_rx_len     = r_rx_len;
        job_valid    = 1'b0;
        job          = '0;
        job.kind     = KIND_TX;

        case (i_item.command)
            CMD_START: begin
                n_items_left = '0;
                n_coil_acc   = '0;
                n_coil_pos   = '0;
                job_valid    = 1'b1;
                job.clr_crc  = 1'b1;
                if (i_item.function_sel > FSEL_READ_REGS ||
                    (i_item.function_sel != FSEL_WRITE_SINGLE &&
                     (i_item.item_count == '0 || i_item.item_count > limit))) begin
                    job.kind = KIND_REJECT;
                end else begin
                    n_active_fn  = i_item.function_sel;
                    job.bytes[0] = r_slave_addr;
                    job.bytes[1] = fn_code(i_item.function_sel);
                    job.bytes[2] = i_item.reg_address[15:8];
                    job.bytes[3] = i_item.reg_address[7:0];
                    job.bytes[4] = {5'b0, i_item.item_count[10:8]};
                    job.bytes[5] = i_item.item_count[7:0];
                    case (i_item.function_sel)
                        FSEL_WRITE_SINGLE: begin
                            job.nbytes   = JIDX_W'(4);
                            n_items_left = 11'd1;
                        end
                        FSEL_WRITE_COILS: begin
                            job.bytes[6] = byte_cnt_sum[10:3];
                            job.nbytes   = JIDX_W'(7);
                            n_items_left = i_item.item_count;
                        end
                        FSEL_WRITE_REGS: begin
                            job.bytes[6] = {i_item.item_count[6:0], 1'b0};
                            job.nbytes   = JIDX_W'(7);
                            n_items_left = i_item.item_count;
                        end
                        default: begin
                            job.nbytes  = JIDX_W'(6);
                            job.add_crc = 1'b1;
                        end
                    endcase
                end
            end
            CMD_PAYLOAD: begin
                if (r_items_left != '0) begin
                    n_items_left = left_dec;
                    if (r_active_fn == FSEL_WRITE_COILS) begin
                        if (pos_inc == 3'd0 || left_dec == '0) begin
                            job_valid    = 1'b1;
                            job.bytes[0] = coil_next;
                            job.nbytes   = JIDX_W'(1);
                            n_coil_acc   = '0;
                            n_coil_pos   = '0;
                        end else begin
                            n_coil_acc = coil_next;
                            n_coil_pos = pos_inc;
                        end
                    end else begin
                        job_valid    = 1'b1;
                        job.bytes[0] = i_item.data_word[15:8];
                        job.bytes[1] = i_item.data_word[7:0];
                        job.nbytes   = JIDX_W'(2);
                    end
                    if (left_dec == '0) begin
                        job.add_crc = 1'b1;
                    end
                end
            end
            CMD_RX_BYTE: begin
                n_rx_crc = crc_feed(r_rx_crc, i_item.rx_byte);
                if (r_rx_len != RX_LEN_MAX) begin
                    n_rx_len = r_rx_len + 9'd1;
                end
            end
            CMD_RX_END: begin
                job_valid = 1'b1;
                job.kind  = KIND_VERDICT;
                job.ok    = (r_rx_len >= RX_LEN_MIN_OK) && (r_rx_crc == '0);
                n_rx_crc  = CRC_INIT;
                n_rx_len  = '0;
            end
            default: begin
                job_valid = 1'b0;
            end
        endcase
    end

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= SLAVE_ADDR_RESET;
        end else if (i_cfg_wr_en) begin
            r_slave_addr <= i_cfg_wr_data;
        end
    end

    // Framing and response-check state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_fn  <= FSEL_READ_INPUTS;
            r_items_left <= '0;
            r_coil_acc   <= '0;
            r_coil_pos   <= '0;
            r_rx_crc     <= CRC_INIT;
            r_rx_len     <= '0;
        end else if (i_accept) begin
            r_active_fn  <= n_active_fn;
            r_items_left <= n_items_left;
            r_coil_acc   <= n_coil_acc;
            r_coil_pos   <= n_coil_pos;
            r_rx_crc     <= n_rx_crc;
            r_rx_len     <= n_rx_len;
        end
    end

    assign o_push = i_accept && job_valid;
    assign o_job  = job;

`ifndef SYNTHESIS
    a_items_need_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_items_left != '0) |-> (r_active_fn == FSEL_WRITE_COILS ||
            r_active_fn == FSEL_WRITE_REGS || r_active_fn == FSEL_WRITE_SINGLE))
        else $error("payload pending for a function without payload");
    a_coil_pos_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_coil_pos != '0) |-> (r_active_fn == FSEL_WRITE_COILS && r_items_left != '0))
        else $error("partial coil byte without a pending coil write");
`endif

endmodule

>>> rtl/mrf_queue.sv
module mrf_queue
    import mrf_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_head_valid,
    output t_job o_head
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full       = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("job pushed into a full queue");
`endif

endmodule

>>> rtl/mrf_back.sv
module mrf_back
    import mrf_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_job      i_head,
    output logic      o_pop,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_res
);

    t_back_state       r_state, n_state;
    logic [15:0]       r_crc, n_crc;
    logic [JIDX_W-1:0] r_idx, n_idx;
    logic              r_out_valid;
    t_out_item         r_out;

    logic              out_free;
    logic              emit;
    t_out_item         res;
    logic              last_byte;
    logic [15:0]       crc_base;
    logic [7:0]        cur_byte;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign last_byte = (r_idx == i_head.nbytes - 1'b1);
    assign crc_base  = (r_idx == '0 && i_head.clr_crc) ? CRC_INIT : r_crc;
    assign cur_byte  = i_head.bytes[r_idx];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_BYTES: begin
                if (i_head_valid && out_free && i_head.kind == KIND_TX &&
                    last_byte && i_head.add_crc) begin
                    n_state = BK_CRC_LO;
                end
            end
            BK_CRC_LO: begin
                if (out_free) begin
                    n_state = BK_CRC_HI;
                end
            end
            BK_CRC_HI: begin
                if (out_free) begin
                    n_state = BK_BYTES;
                end
            end
            default: n_state = BK_BYTES;
        endcase
    end

    // Emission, CRC and job sequencing.
    always_comb begin
        emit  = 1'b0;
        o_pop = 1'b0;
        n_crc = r_crc;
        n_idx = r_idx;
        res   = '0;
        case (r_state)
            BK_BYTES: begin
                if (i_head_valid && out_free) begin
                    emit         = 1'b1;
                    res.out_kind = i_head.kind;
                    case (i_head.kind)
                        KIND_TX: begin
                            res.tx_byte = cur_byte;
                            n_crc       = crc_feed(crc_base, cur_byte);
                            if (last_byte) begin
                                o_pop = 1'b1;
                                n_idx = '0;
                            end else begin
                                n_idx = r_idx + 1'b1;
                            end
                        end
                        KIND_VERDICT: begin
                            res.frame_last  = 1'b1;
                            res.response_ok = i_head.ok;
                            o_pop           = 1'b1;
                        end
                        default: begin
                            res.frame_last = 1'b1;
                            n_crc          = CRC_INIT;
                            o_pop          = 1'b1;
                        end
                    endcase
                end
            end
            BK_CRC_LO: begin
                if (out_free) begin
                    emit         = 1'b1;
                    res.out_kind = KIND_TX;
                    res.tx_byte  = r_crc[7:0];
                end
            end
            BK_CRC_HI: begin
                if (out_free) begin
                    emit           = 1'b1;
                    res.out_kind   = KIND_TX;
                    res.tx_byte    = r_crc[15:8];
                    res.frame_last = 1'b1;
                    n_crc          = CRC_INIT;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_BYTES;
            r_crc   <= CRC_INIT;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_crc   <= n_crc;
            r_idx   <= n_idx;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_out;

`ifndef SYNTHESIS
    a_crc_reset_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_CRC_HI && out_free) |=> (r_crc == CRC_INIT && r_state == BK_BYTES))
        else $error("transmit CRC not restarted after the closing byte");
`endif

endmodule

>>> rtl/modbus_rtu_master_framer_top.sv
// Channel   Handshake                      Payload
// input     i_in_valid / o_in_stall        i_in_req  (t_in_item)
// output    o_out_valid / i_out_stall      o_out_res (t_out_item)
// config    i_cfg_wr_en                    i_cfg_wr_data (slave address)
//
// The front end takes one request per cycle while its four-entry job queue has room.
// The back end emits one result per cycle unless the output stalls: a start yields 4 to 8 results,
// a register payload 2 or 4, a coil payload 0, 1 or 3, a verdict or rejection 1.
// Reset is synchronous and active low; it takes effect at the next clock edge.
// A stalled output holds in the output register while the queue keeps filling.
module modbus_rtu_master_framer_top
    import mrf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in_item   i_in_req,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out_item  o_out_res
);

    logic q_full;
    logic q_push;
    logic q_pop;
    logic q_head_valid;
    t_job front_job;
    t_job q_head;
    logic in_accept;

    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    // Request classification and framing state.
    mrf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_accept      (in_accept),
        .i_item        (i_in_req),
        .o_push        (q_push),
        .o_job         (front_job)
    );

    // Job queue.
    mrf_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_job        (front_job),
        .i_pop        (q_pop),
        .o_full       (q_full),
        .o_head_valid (q_head_valid),
        .o_head       (q_head)
    );

    // Byte emission and transmit CRC.
    mrf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_head_valid),
        .i_head       (q_head),
        .o_pop        (q_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_res    (o_out_res)
    );

endmodule

>>> bench/tb_modbus_rtu_master_framer_top.sv
`timescale 1ns / 100ps

module tb_modbus_rtu_master_framer_top;
    import mrf_pkg::*;

    localparam int SETTLE_CYCLES = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_cfg_wr_en = 1'b0;
    logic [7:0] i_cfg_wr_data = 8'h00;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_req = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_res;

    // Framer and response checker state as the bench predicts it.
    logic [7:0]  slave_addr = SLAVE_ADDR_RESET;
    logic [15:0] req_crc = CRC_INIT;
    logic [2:0]  req_function = FSEL_READ_INPUTS;
    logic [10:0] words_left = '0;
    logic [7:0]  coil_byte = '0;
    logic [2:0]  coil_pos = '0;
    logic [15:0] resp_crc = CRC_INIT;
    logic [8:0]  resp_len = '0;

    t_out_item expected_results[$];
    t_in_item  pending_reqs[$];
    int        queued_total = 0;
    int        err_count = 0;
    int        idle_cycles = 0;
    int        gap_left = 0;
    int        stall_left = 0;
    bit        stalling = 1'b0;
    bit        req_taken = 1'b0;
    bit        quiet = 1'b0;

    modbus_rtu_master_framer_top DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_req     (i_in_req),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_res    (o_out_res)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // CRC-16/MODBUS, reflected, one byte at a time.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] data);
        logic [15:0] acc;
        acc = crc ^ {8'h00, data};
        repeat (8) begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY) : (acc >> 1);
        end
        return acc;
    endfunction

    // Highest count accepted for each function; zero where none applies.
    function automatic logic [10:0] count_limit(input logic [2:0] fsel);
        case (fsel)
            FSEL_READ_INPUTS: return MAX_COILS;
            FSEL_WRITE_COILS: return COIL_WRITE_LIMIT;
            FSEL_WRITE_REGS:  return REG_WRITE_LIMIT;
            FSEL_READ_REGS:   return REG_READ_LIMIT;
            default:          return 11'd0;
        endcase
    endfunction

    function automatic void push_result(input t_out_kind kind, input logic [7:0] tx,
                                        input logic last, input logic ok);
        t_out_item res;
        res.out_kind = kind;
        res.tx_byte = tx;
        res.frame_last = last;
        res.response_ok = ok;
        expected_results.push_back(res);
    endfunction

    function automatic void send_byte(input logic [7:0] b);
        req_crc = crc16_byte(req_crc, b);
        push_result(KIND_TX, b, 1'b0, 1'b0);
    endfunction

    function automatic void clear_request();
        req_crc = CRC_INIT;
        words_left = '0;
        coil_byte = '0;
        coil_pos = '0;
    endfunction

    // The CRC goes out low byte first, and its high byte ends the frame.
    function automatic void close_request();
        push_result(KIND_TX, req_crc[7:0], 1'b0, 1'b0);
        push_result(KIND_TX, req_crc[15:8], 1'b1, 1'b0);
        clear_request();
    endfunction

    // Works out the results one accepted request causes and queues them.
    function automatic void predict_request(input t_in_item req);
        logic [7:0] code;
        logic       ok;
        case (req.command)
            CMD_START: begin
                clear_request();
                if (req.function_sel > FSEL_READ_REGS ||
                    (req.function_sel != FSEL_WRITE_SINGLE &&
                     (req.item_count == 11'd0 ||
                      req.item_count > count_limit(req.function_sel)))) begin
                    push_result(KIND_REJECT, 8'h00, 1'b1, 1'b0);
                end else begin
                    req_function = req.function_sel;
                    case (req.function_sel)
                        FSEL_READ_INPUTS: code = FC_READ_INPUTS;
                        FSEL_WRITE_COILS: code = FC_WRITE_COILS;
                        FSEL_WRITE_REGS:  code = FC_WRITE_REGS;
                        FSEL_WRITE_SINGLE: code = FC_WRITE_SINGLE;
                        default:          code = FC_READ_REGS;
                    endcase
                    send_byte(slave_addr);
                    send_byte(code);
                    send_byte(req.reg_address[15:8]);
                    send_byte(req.reg_address[7:0]);
                    if (req.function_sel == FSEL_WRITE_SINGLE) begin
                        words_left = 11'd1;
                    end else begin
                        send_byte({5'd0, req.item_count[10:8]});
                        send_byte(req.item_count[7:0]);
                        if (req.function_sel == FSEL_WRITE_COILS) begin
                            send_byte(8'((12'(req.item_count) + 12'd7) >> 3));
                            words_left = req.item_count;
                        end else if (req.function_sel == FSEL_WRITE_REGS) begin
                            send_byte({req.item_count[6:0], 1'b0});
                            words_left = req.item_count;
                        end else begin
                            close_request();
                        end
                    end
                end
            end
            CMD_PAYLOAD: begin
                // A payload with no request waiting for it is dropped.
                if (words_left != 11'd0) begin
                    if (req_function == FSEL_WRITE_COILS) begin
                        if (req.data_word[0]) begin
                            coil_byte[coil_pos] = 1'b1;
                        end
                        coil_pos = coil_pos + 3'd1;
                        words_left = words_left - 11'd1;
                        if (coil_pos == 3'd0 || words_left == 11'd0) begin
                            send_byte(coil_byte);
                            coil_byte = '0;
                            coil_pos = '0;
                        end
                    end else begin
                        send_byte(req.data_word[15:8]);
                        send_byte(req.data_word[7:0]);
                        words_left = words_left - 11'd1;
                    end
                    if (words_left == 11'd0) begin
                        close_request();
                    end
                end
            end
            CMD_RX_BYTE: begin
                resp_crc = crc16_byte(resp_crc, req.rx_byte);
                if (resp_len != RX_LEN_MAX) begin
                    resp_len = resp_len + 9'd1;
                end
            end
            default: begin
                ok = (resp_len >= RX_LEN_MIN_OK) && (resp_crc == 16'h0000);
                push_result(KIND_VERDICT, 8'h00, 1'b1, ok);
                resp_crc = CRC_INIT;
                resp_len = '0;
            end
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [7:0] expv,
                                        input logic [7:0] actv);
        if (expv !== actv) begin
            $display("t=%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, expv, actv);
            err_count++;
        end
    endfunction

    // Request with every field random except the command.
    function automatic t_in_item random_item(input t_cmd cmd);
        t_in_item req;
        req.command = cmd;
        req.function_sel = 3'($urandom);
        req.reg_address = 16'($urandom);
        req.item_count = 11'($urandom);
        req.data_word = 16'($urandom);
        req.rx_byte = 8'($urandom);
        return req;
    endfunction

    function automatic void queue_req(input t_in_item req);
        pending_reqs.push_back(req);
        queued_total++;
    endfunction

    function automatic void queue_start(input logic [2:0] fsel, input logic [15:0] addr,
                                        input logic [10:0] cnt);
        t_in_item req;
        req = random_item(CMD_START);
        req.function_sel = fsel;
        req.reg_address = addr;
        req.item_count = cnt;
        queue_req(req);
    endfunction

    function automatic void queue_payload(input logic [15:0] data);
        t_in_item req;
        req = random_item(CMD_PAYLOAD);
        req.data_word = data;
        queue_req(req);
    endfunction

    function automatic void queue_rx_byte(input logic [7:0] b);
        t_in_item req;
        req = random_item(CMD_RX_BYTE);
        req.rx_byte = b;
        queue_req(req);
    endfunction

    // A response of random bytes, closed by its CRC or by two random bytes.
    function automatic void queue_response(input int nbytes, input bit intact);
        logic [15:0] crc;
        logic [7:0]  b;
        crc = CRC_INIT;
        for (int k = 0; k < nbytes; k++) begin
            b = 8'($urandom);
            crc = crc16_byte(crc, b);
            queue_rx_byte(b);
        end
        if (intact) begin
            queue_rx_byte(crc[7:0]);
            queue_rx_byte(crc[15:8]);
        end else begin
            queue_rx_byte(8'($urandom));
            queue_rx_byte(8'($urandom));
        end
        queue_req(random_item(CMD_RX_END));
    endfunction

    // A complete write request with all of its payload.
    function automatic void queue_write_frame(input logic [2:0] fsel, input logic [10:0] cnt);
        int nwords;
        queue_start(fsel, 16'($urandom), cnt);
        nwords = (fsel == FSEL_WRITE_SINGLE) ? 1 : int'(cnt);
        repeat (nwords) begin
            queue_payload(16'($urandom));
        end
    endfunction

    // Mostly well-formed traffic with random content, plus broken and noisy requests.
    function automatic void queue_random_traffic(input int n_items);
        int          stop_at;
        int          pick;
        logic [2:0]  fsel;
        logic [10:0] cnt;
        stop_at = queued_total + n_items;
        while (queued_total < stop_at) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                case ($urandom_range(0, 2))
                    0:       queue_write_frame(FSEL_WRITE_COILS, 11'($urandom_range(1, 20)));
                    1:       queue_write_frame(FSEL_WRITE_REGS, 11'($urandom_range(1, 6)));
                    default: queue_write_frame(FSEL_WRITE_SINGLE, 11'($urandom));
                endcase
            end else if (pick < 50) begin
                fsel = ($urandom_range(0, 1) != 0) ? FSEL_READ_REGS : FSEL_READ_INPUTS;
                cnt = 11'($urandom_range(1, count_limit(fsel)));
                queue_start(fsel, 16'($urandom), cnt);
            end else if (pick < 60) begin
                fsel = 3'($urandom_range(0, 7));
                if (fsel == FSEL_WRITE_SINGLE || fsel > FSEL_READ_REGS) begin
                    queue_start(FSEL_READ_REGS + 3'($urandom_range(1, 3)), 16'($urandom),
                                11'($urandom));
                end else if ($urandom_range(0, 1) != 0) begin
                    queue_start(fsel, 16'($urandom), 11'd0);
                end else begin
                    cnt = 11'($urandom_range(int'(count_limit(fsel)) + 1, 2047));
                    queue_start(fsel, 16'($urandom), cnt);
                end
            end else if (pick < 70) begin
                // A write that is never finished; a later start abandons it.
                fsel = ($urandom_range(0, 1) != 0) ? FSEL_WRITE_COILS : FSEL_WRITE_REGS;
                cnt = 11'($urandom_range(9, count_limit(fsel)));
                queue_start(fsel, 16'($urandom), cnt);
                repeat ($urandom_range(0, 3)) begin
                    queue_payload(16'($urandom));
                end
            end else if (pick < 90) begin
                queue_response($urandom_range(0, 10), $urandom_range(0, 3) != 0);
            end else begin
                queue_req(random_item(t_cmd'($urandom_range(0, 3))));
            end
        end
    endfunction

    // Lets everything drain, then gives the block time to finish silent work.
    task automatic wait_until_idle();
        while (pending_reqs.size() != 0 || i_in_valid) begin
            @(posedge i_clk);
        end
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_slave_address(input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        slave_addr = value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    // Request driver: holds a request until it is taken, with random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_reqs.size() == 0) begin
                i_in_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                gap_left = $urandom_range(0, 9);
                i_in_valid <= 1'b0;
            end else begin
                i_in_req <= pending_reqs.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    // Result side stall: alternating stall and run bursts.
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stalling = ($urandom_range(0, 2) == 0);
            stall_left = stalling ? $urandom_range(1, 10) : $urandom_range(1, 20);
        end
        stall_left--;
        i_out_stall <= stalling && !quiet;
    end

    // Monitor: predicts on each taken request and checks each taken result.
    always @(posedge i_clk) begin
        t_out_item want;
        req_taken = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                req_taken = 1'b1;
                predict_request(i_in_req);
            end
            if (o_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $display("t=%0t: unexpected result, expected none, actual %p",
                             $time, o_out_res);
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("out_kind", 8'(want.out_kind), 8'(o_out_res.out_kind));
                    check_field("tx_byte", want.tx_byte, o_out_res.tx_byte);
                    check_field("frame_last", 8'(want.frame_last), 8'(o_out_res.frame_last));
                    check_field("response_ok", 8'(want.response_ok),
                                8'(o_out_res.response_ok));
                end
            end
        end
    end

    // Watchdog on cycles without any handshake.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("t=%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: boundaries, every function, rejections and special cases.
        queue_start(FSEL_READ_INPUTS, 16'h0000, 11'd1);
        queue_start(FSEL_READ_INPUTS, 16'hFFFF, MAX_COILS);
        queue_start(FSEL_READ_REGS, 16'h8000, REG_READ_LIMIT);
        queue_start(FSEL_READ_INPUTS, 16'h1234, MAX_COILS + 11'd1);
        queue_start(FSEL_READ_REGS, 16'h0001, REG_READ_LIMIT + 11'd1);
        queue_start(FSEL_WRITE_REGS, 16'h0002, REG_WRITE_LIMIT + 11'd1);
        queue_start(FSEL_WRITE_COILS, 16'h0003, COIL_WRITE_LIMIT + 11'd1);
        queue_start(FSEL_WRITE_REGS, 16'h0004, 11'd0);
        queue_start(FSEL_READ_REGS + 3'd1, 16'h0005, 11'h7FF);
        queue_start(FSEL_READ_REGS + 3'd3, 16'h0006, 11'd1);
        // Single write ignores its count.
        queue_start(FSEL_WRITE_SINGLE, 16'hA5A5, 11'd0);
        queue_payload(16'hFFFF);
        queue_start(FSEL_WRITE_COILS, 16'h0013, 11'd3);
        queue_payload(16'h0001);
        queue_payload(16'hFFFE);
        queue_payload(16'h0001);
        queue_start(FSEL_WRITE_REGS, 16'h0100, 11'd1);
        queue_payload(16'h8001);
        // Stray payload, then a write abandoned by a new start.
        queue_payload(16'h5555);
        queue_start(FSEL_WRITE_REGS, 16'h0200, 11'd2);
        queue_payload(16'h1234);
        queue_start(FSEL_WRITE_COILS, 16'h0300, COIL_WRITE_LIMIT);
        queue_payload(16'h0001);
        queue_start(FSEL_READ_REGS, 16'h0400, 11'd1);
        // Shortest good response, a two-byte one with zero residue, an empty one.
        queue_response(1, 1'b1);
        queue_response(0, 1'b1);
        queue_req(random_item(CMD_RX_END));
        wait_until_idle();

        write_slave_address(8'd0);
        queue_random_traffic(45);
        wait_until_idle();

        write_slave_address(8'd247);
        queue_random_traffic(40);
        wait_until_idle();

        write_slave_address(8'hFF);
        queue_random_traffic(30);
        wait_until_idle();

        // Last part runs with no gaps and no stalls.
        write_slave_address(8'($urandom_range(1, 246)));
        quiet = 1'b1;
        queue_random_traffic(30);
        wait_until_idle();

        if (expected_results.size() != 0) begin
            $display("t=%0t: %0d expected results never arrived",
                     $time, expected_results.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
